>>> hdl/simple_moving_average_defines.svh
// assertion macros for the moving average block
// expects clk and rst in the scope where a macro is used
`ifndef SIMPLE_MOVING_AVERAGE_DEFINES_SVH
`define SIMPLE_MOVING_AVERAGE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SMA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("simple_moving_average: same-cycle check failed");
`define SMA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("simple_moving_average: next-cycle check failed");
`else
`define SMA_ASSERT_IMPL(name, ante, cons)
`define SMA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> hdl/sma_pkg.sv
// shared types and field widths for the moving average block
// no dependencies
package sma_pkg;

  localparam int VALUE_BITS = 16;
  localparam int YEAR_BITS  = 12;
  localparam int MONTH_BITS = 4;
  localparam int DAY_BITS   = 5;
  localparam int INDEX_BITS = 16;
  localparam int WLEN_BITS  = 7;

  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 7'd7;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sample_value;
    logic [YEAR_BITS-1:0]  year_in;
    logic [MONTH_BITS-1:0] month_in;
    logic [DAY_BITS-1:0]   day_in;
  } sample_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] average_value;
    logic [YEAR_BITS-1:0]  year_out;
    logic [MONTH_BITS-1:0] month_out;
    logic [DAY_BITS-1:0]   day_out;
    logic [INDEX_BITS-1:0] sample_index;
  } result_t;

endpackage

>>> hdl/sma_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module sma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/sma_div.sv
// restoring divider, one quotient bit per cycle
// standalone, used by simple_moving_average
module sma_div #(
  parameter int NUM_BITS = 23,
  parameter int DEN_BITS = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [NUM_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [CNT_BITS-1:0] count;
  logic [DEN_BITS-1:0] remainder;
  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS:0]   shifted;
  logic                fits;

  assign shifted = {remainder, quotient[NUM_BITS-1]};
  assign fits    = (shifted >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      count <= CNT_BITS'(NUM_BITS);
    end else if (busy) begin
      count <= count - CNT_BITS'(1);
      if (count == CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      den       <= divisor;
    end else if (busy) begin
      if (fits) begin
        remainder <= DEN_BITS'(shifted - {1'b0, den});
      end else begin
        remainder <= shifted[DEN_BITS-1:0];
      end
      quotient <= {quotient[NUM_BITS-2:0], fits};
    end
  end

endmodule

>>> hdl/simple_moving_average.sv
// simple moving average over a configurable window of dated samples
// uses sma_pkg, sma_ram, sma_div and simple_moving_average_defines.svh
//
// in_valid/in_ready/in_data carry one sample with its date. once at least w
// samples have arrived since reset (w = window_length, 0 taken as 1, values
// above MAX_WINDOW taken as MAX_WINDOW) each sample yields one transfer on
// out_valid/out_ready/out_data: the truncated mean of the newest w samples,
// the date of the sample and its wrapping index. earlier samples yield none.
// cfg_we writes window_length at once; write it only while the block is idle.
// an item is worked one at a time. a sample that yields no result goes
// straight back to idle. otherwise the delay line ram is read back one entry
// a cycle (w entries), then the sum (23 bits wide with default parameters)
// goes through a bit-serial divider, and the quotient is registered onto
// out_valid/out_data as the result.
// the output register holds one result; a new sample is taken while it waits,
// but the next result is held in the divider until the receiver takes it.
// reset clears the counters and sets window_length to 7; the ram needs no
// clearing since only entries written since reset are ever summed.
`include "simple_moving_average_defines.svh"

module simple_moving_average #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sma_pkg::WLEN_BITS-1:0]    cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sma_pkg::sample_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sma_pkg::result_t                 out_data
);

  import sma_pkg::*;

  localparam int DATA_BITS = (SAMPLE_BITS < VALUE_BITS) ? SAMPLE_BITS : VALUE_BITS;
  localparam int WB        = $clog2(MAX_WINDOW + 1);
  localparam int AW        = $clog2(MAX_WINDOW);
  localparam int SUM_BITS  = DATA_BITS + WB;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;

  logic [2:0]            state;
  logic [WLEN_BITS-1:0]  window_length;
  logic [AW-1:0]         write_slot;
  logic [AW-1:0]         rd_slot;
  logic [INDEX_BITS-1:0] samples_seen;
  logic [WB-1:0]         fill_count;
  logic [WB-1:0]         fill_next;
  logic [WB-1:0]         eff_window;
  logic [WB-1:0]         win;
  logic [WB-1:0]         reads_left;
  logic                  rd_pend;
  logic [SUM_BITS-1:0]   acc;
  logic [31:0]           wl_ext;
  logic                  accept;
  logic                  out_load;
  logic [DATA_BITS-1:0]  ram_rdata;
  logic                  div_busy;
  logic                  div_done;
  logic [SUM_BITS-1:0]   quotient;
  logic [YEAR_BITS-1:0]  hold_year;
  logic [MONTH_BITS-1:0] hold_month;
  logic [DAY_BITS-1:0]   hold_day;
  logic [INDEX_BITS-1:0] hold_index;

  assign wl_ext = 32'(window_length);

  always_comb begin
    if (wl_ext == 32'd0) begin
      eff_window = WB'(1);
    end else if (wl_ext > 32'(MAX_WINDOW)) begin
      eff_window = WB'(MAX_WINDOW);
    end else begin
      eff_window = WB'(wl_ext);
    end
  end

  assign fill_next = (fill_count == WB'(MAX_WINDOW)) ? fill_count : fill_count + WB'(1);
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == ST_DIV) && div_done && (!out_valid || out_ready);

  sma_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_history (
    .clk   (clk),
    .we    (accept),
    .waddr (write_slot),
    .wdata (in_data.sample_value[DATA_BITS-1:0]),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  sma_div #(
    .NUM_BITS (SUM_BITS),
    .DEN_BITS (WB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_START),
    .dividend (acc),
    .divisor  (win),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= WLEN_RESET;
      write_slot    <= '0;
      samples_seen  <= '0;
      fill_count    <= '0;
      out_valid     <= 1'b0;
      rd_pend       <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_length <= cfg_wdata;
      end
      rd_pend <= (state == ST_SUM);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            write_slot   <= (write_slot == AW'(MAX_WINDOW - 1)) ? '0 : write_slot + AW'(1);
            samples_seen <= samples_seen + INDEX_BITS'(1);
            fill_count   <= fill_next;
            // skip the sum entirely when no result is due
            state        <= (fill_next >= eff_window) ? ST_SUM : ST_IDLE;
          end
        end
        ST_SUM: begin
          if (reads_left == WB'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= ST_START;
        ST_START: state <= ST_DIV;
        ST_DIV: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      win        <= eff_window;
      reads_left <= eff_window;
      rd_slot    <= write_slot;
      acc        <= '0;
      hold_year  <= in_data.year_in;
      hold_month <= in_data.month_in;
      hold_day   <= in_data.day_in;
      hold_index <= samples_seen;
    end else begin
      if (state == ST_SUM) begin
        // walk back from the newest entry, wrapping below slot zero
        rd_slot    <= (rd_slot == '0) ? AW'(MAX_WINDOW - 1) : rd_slot - AW'(1);
        reads_left <= reads_left - WB'(1);
      end
      if (rd_pend) begin
        acc <= acc + SUM_BITS'(ram_rdata);
      end
    end
    if (out_load) begin
      out_data.average_value <= VALUE_BITS'(quotient[DATA_BITS-1:0]);
      out_data.year_out      <= hold_year;
      out_data.month_out     <= hold_month;
      out_data.day_out       <= hold_day;
      out_data.sample_index  <= hold_index;
    end
  end

  `SMA_ASSERT_NEXT(a_fill_after_accept, in_valid && in_ready, fill_count != '0)
  `SMA_ASSERT_IMPL(a_fill_bounded, 1'b1, fill_count <= WB'(MAX_WINDOW))
  `SMA_ASSERT_NEXT(a_div_starts, state == ST_START, div_busy)
  `SMA_ASSERT_IMPL(a_out_from_div, $rose(out_valid), $past(state) == ST_DIV)

endmodule
